// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the top level of the charge converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CCAH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define CCAH_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/core/ccah_pkg.sv =====
// Package for the charge converter: widths, constants and the charge-per-count table.
package ccah_pkg;

  localparam int COUNT_W  = 16;
  localparam int LSB_W    = 24;
  localparam int CHARGE_W = COUNT_W + LSB_W;
  localparam int SHIFT_W  = 4;
  localparam int SEL_W    = 3;
  localparam int AMPS_W   = 10;
  localparam int NANO_W   = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // One amp-hour in nA-hr.
  localparam logic [NANO_W-1:0] NANO_PER_AH = NANO_W'(1000000000);

  // Quotient estimate: (charge >> PRE_SHIFT) * RECIP >> RECIP_SHIFT, never above
  // the true quotient and at most one below it.
  localparam int PRE_SHIFT   = 20;
  localparam int TOP_W       = CHARGE_W - PRE_SHIFT;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(1125899);
  localparam int EST_PROD_W  = TOP_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE = 2'd0,
    CFG_PEAK_SEL = 2'd1
  } cfg_idx_t;

  typedef logic [CHARGE_W-1:0] charge_t;

  // Charge per counter step in nA-hr for each peak current setting.
  function automatic logic [LSB_W-1:0] charge_per_count(input logic [SEL_W-1:0] sel);
    logic [LSB_W-1:0] v;
    case (sel)
      3'd0:    v = LSB_W'(745700);
      3'd1:    v = LSB_W'(1491000);
      3'd2:    v = LSB_W'(2237000);
      3'd3:    v = LSB_W'(2983000);
      3'd4:    v = LSB_W'(3728000);
      3'd5:    v = LSB_W'(7457000);
      3'd6:    v = LSB_W'(11180000);
      default: v = LSB_W'(14910000);
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/charge_count_to_amp_hours.sv =====
// Top level of the charge counter to amp-hour converter.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    in_charge_count[15:0]
//  out      out  out_valid/out_ready  out_whole_amp_hours[9:0], out_fraction_nanoamp_hours[29:0]
//  cfg      in   cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[7:0]
//
// Five register stages: count times table entry, prescale shift, quotient estimate,
// remainder, one-step correction. One beat per cycle while the output is not stalled.
// Ready runs back through the stages, so a stalled output holds every beat in place.
// Reset empties the pipeline and clears both registers; cfg_ready is always high.
module charge_count_to_amp_hours
  import ccah_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_W-1:0]    in_charge_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [AMPS_W-1:0]     out_whole_amp_hours,
  output logic [NANO_W-1:0]     out_fraction_nanoamp_hours,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  logic [SHIFT_W-1:0] prescale_r;
  logic [SEL_W-1:0]   peak_sel_r;

  logic               p_vld_r;
  charge_t            p_prod_r;
  logic [SHIFT_W-1:0] p_shift_r;
  logic               s_vld_r;
  charge_t            s_charge_r;

  logic               p_rdy, s_rdy, div_ready;
  charge_t            prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      peak_sel_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRESCALE: prescale_r <= cfg_data[SHIFT_W-1:0];
        CFG_PEAK_SEL: peak_sel_r <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_rdy    = !s_vld_r || div_ready;
  assign p_rdy    = !p_vld_r || s_rdy;
  assign in_ready = p_rdy;

  // floor(count * lsb / 2^M) equals the split-and-add-back sum exactly
  assign prod = CHARGE_W'(in_charge_count) * CHARGE_W'(charge_per_count(peak_sel_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else begin
      if (p_rdy) p_vld_r <= in_valid;
      if (s_rdy) s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p_rdy && in_valid) begin
      p_prod_r  <= prod;
      p_shift_r <= prescale_r;
    end
    if (s_rdy && p_vld_r) begin
      s_charge_r <= p_prod_r >> p_shift_r;
    end
  end

  ccah_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_vld_r),
    .in_ready  (div_ready),
    .in_charge (s_charge_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_amps  (out_whole_amp_hours),
    .out_nano  (out_fraction_nanoamp_hours)
  );

  `CCAH_ASSERT_IMP(a_frac_range, out_valid, out_fraction_nanoamp_hours < NANO_PER_AH, "fraction not below one amp-hour")
  `CCAH_ASSERT_IMP(a_amps_range, out_valid, out_whole_amp_hours <= AMPS_W'(977), "amp-hours above full-scale charge")
  `CCAH_ASSERT_IMP(a_ready_chain, out_ready, in_ready, "pipeline stalls with output taken")
  `CCAH_ASSERT_IMP(a_beat_flow, in_valid && in_ready && out_ready, ##1 p_vld_r, "accepted beat lost at first stage")

endmodule

// ===== rtl/core/ccah_divider.sv =====
// Three-stage split of a charge in nA-hr into whole amp-hours and the nA-hr fraction.
module ccah_divider
  import ccah_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  charge_t           in_charge,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [AMPS_W-1:0] out_amps,
  output logic [NANO_W-1:0] out_nano
);

  localparam int REM_W = NANO_W + 1;

  logic                    e_vld_r;
  charge_t                 e_charge_r;
  logic [AMPS_W-1:0]       e_est_r;
  logic                    r_vld_r;
  logic [REM_W-1:0]        r_rem_r;
  logic [AMPS_W-1:0]       r_est_r;
  logic                    o_vld_r;
  logic [AMPS_W-1:0]       o_amps_r;
  logic [NANO_W-1:0]       o_nano_r;

  logic                    e_rdy, r_rdy, o_rdy;
  logic [EST_PROD_W-1:0]   est_prod;
  logic [CHARGE_W-1:0]     est_back;
  logic [CHARGE_W-1:0]     rem_full;

  assign o_rdy    = !o_vld_r || out_ready;
  assign r_rdy    = !r_vld_r || o_rdy;
  assign e_rdy    = !e_vld_r || r_rdy;
  assign in_ready = e_rdy;

  assign est_prod = EST_PROD_W'(in_charge[CHARGE_W-1:PRE_SHIFT]) * EST_PROD_W'(RECIP);
  assign est_back = CHARGE_W'(e_est_r) * CHARGE_W'(NANO_PER_AH);
  assign rem_full = e_charge_r - est_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
      r_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (e_rdy) e_vld_r <= in_valid;
      if (r_rdy) r_vld_r <= e_vld_r;
      if (o_rdy) o_vld_r <= r_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e_rdy && in_valid) begin
      e_charge_r <= in_charge;
      e_est_r    <= est_prod[RECIP_SHIFT +: AMPS_W];
    end
    // remainder stays below two amp-hours
    if (r_rdy && e_vld_r) begin
      r_rem_r <= rem_full[REM_W-1:0];
      r_est_r <= e_est_r;
    end
    if (o_rdy && r_vld_r) begin
      if (r_rem_r >= REM_W'(NANO_PER_AH)) begin
        o_amps_r <= r_est_r + AMPS_W'(1);
        o_nano_r <= NANO_W'(r_rem_r - REM_W'(NANO_PER_AH));
      end else begin
        o_amps_r <= r_est_r;
        o_nano_r <= r_rem_r[NANO_W-1:0];
      end
    end
  end

  assign out_valid = o_vld_r;
  assign out_amps  = o_amps_r;
  assign out_nano  = o_nano_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the charge count to amp-hour converter.
module tb_top
  import ccah_pkg::*;
();

  localparam int LIMIT_CYCLES = 200000;
  localparam longint unsigned ONE_AH_NAH  = 64'd1000000000;
  localparam longint unsigned SPLIT_NAH   = 64'd10000;
  localparam longint unsigned SPLIT_PER_AH = ONE_AH_NAH / SPLIT_NAH;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [AMPS_W-1:0] amps;
    logic [NANO_W-1:0] nano;
  } ah_reading_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [COUNT_W-1:0]    in_charge_count = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [AMPS_W-1:0]     out_whole_amp_hours;
  logic [NANO_W-1:0]     out_fraction_nanoamp_hours;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_PRESCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // nA-hr per counter step, one entry per peak current setting
  longint unsigned nah_per_count [8] = '{64'd745700, 64'd1491000, 64'd2237000, 64'd2983000,
                                         64'd3728000, 64'd7457000, 64'd11180000, 64'd14910000};

  logic [SHIFT_W-1:0] prescale_m = '0;
  logic [SEL_W-1:0]   peak_sel = '0;
  logic               in_taken = 1'b0;
  logic               cfg_taken = 1'b0;
  int                 items_in = 0;
  int                 mismatches = 0;
  int                 hold_left = 0;
  logic               held_once = 1'b0;
  logic               calm;

  logic [COUNT_W-1:0] count_backlog [$];
  ah_reading_t        ah_expected [$];

  charge_count_to_amp_hours dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_charge_count            (in_charge_count),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_whole_amp_hours        (out_whole_amp_hours),
    .out_fraction_nanoamp_hours (out_fraction_nanoamp_hours),
    .cfg_valid                  (cfg_valid),
    .cfg_ready                  (cfg_ready),
    .cfg_index                  (cfg_index),
    .cfg_data                   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Split the quotient at 10 uA-hr so products stay small, then add back the
  // bits lost to the prescale shift and carry whole amp-hours out of the fraction.
  function automatic ah_reading_t charge_to_ah(input logic [COUNT_W-1:0] cnt,
                                               input logic [SHIFT_W-1:0] m,
                                               input logic [SEL_W-1:0] sel);
    longint unsigned step, q, rem, whole, frac, amps, nano;
    ah_reading_t r;
    step  = nah_per_count[sel];
    q     = step >> m;
    rem   = step & ((64'd1 << m) - 64'd1);
    whole = 64'(cnt) * (q / SPLIT_NAH);
    frac  = 64'(cnt) * (q % SPLIT_NAH);
    amps  = whole / SPLIT_PER_AH;
    nano  = (whole % SPLIT_PER_AH) * SPLIT_NAH + frac;
    nano  = nano + ((rem * 64'(cnt)) >> m);
    amps  = amps + nano / ONE_AH_NAH;
    nano  = nano % ONE_AH_NAH;
    r.amps = amps[AMPS_W-1:0];
    r.nano = nano[NANO_W-1:0];
    return r;
  endfunction

  // No idling on either side for a stretch of the random part.
  assign calm = (items_in >= 300) && (items_in < 420);

  always @(posedge clk) begin : check
    ah_reading_t head;
    if (!rst_n) begin
      prescale_m <= '0;
      peak_sel   <= '0;
      in_taken   <= 1'b0;
      cfg_taken  <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      cfg_taken <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRESCALE: prescale_m <= cfg_data[SHIFT_W-1:0];
          CFG_PEAK_SEL: peak_sel <= cfg_data[SEL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (ah_expected.size() == 0) begin
          $error("unexpected result beat: whole_amp_hours %0d, fraction_nanoamp_hours %0d",
                 out_whole_amp_hours, out_fraction_nanoamp_hours);
          mismatches++;
        end else begin
          head = ah_expected.pop_front();
          if (out_whole_amp_hours !== head.amps) begin
            $error("whole_amp_hours: expected %0d, actual %0d", head.amps, out_whole_amp_hours);
            mismatches++;
          end
          if (out_fraction_nanoamp_hours !== head.nano) begin
            $error("fraction_nanoamp_hours: expected %0d, actual %0d",
                   head.nano, out_fraction_nanoamp_hours);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        ah_expected.push_back(charge_to_ah(in_charge_count, prescale_m, peak_sel));
        items_in <= items_in + 1;
      end
    end
  end

  // Sender: hold the beat until taken, then offer the next or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (count_backlog.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
        in_valid        <= 1'b1;
        in_charge_count <= count_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while the sender keeps pushing.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && count_backlog.size() >= 40 && items_in >= 30) begin
      out_ready <= 1'b0;
      hold_left <= 250;
      held_once <= 1'b1;
    end else if (!calm && $urandom_range(99) < 13) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : timeout
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
  endtask

  // Upper data bits are junk on purpose; a spare index goes last so a decode bug shows.
  task automatic set_config(input logic [CFG_DATA_W-1:0] m_raw,
                            input logic [CFG_DATA_W-1:0] sel_raw);
    write_reg(CFG_PRESCALE, m_raw);
    write_reg(CFG_PEAK_SEL, sel_raw);
    write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom_range(255)));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (count_backlog.size() != 0 || in_valid || ah_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int n;
    int p;
    logic [COUNT_W-1:0] v;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: smallest entry, no prescale
    count_backlog = '{16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
    drain_results();

    // largest result: full counter, top entry, no prescale
    set_config(8'hF0, 8'hFF);
    count_backlog = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    drain_results();

    // fraction lands exactly on one amp-hour boundary
    set_config(8'h00, 8'h04);
    count_backlog = '{16'd62500, 16'd62499, 16'h0001};
    drain_results();

    // deepest prescale truncates the added-back remainder
    set_config(8'hFF, 8'hF8);
    count_backlog = '{16'hFFFF, 16'h0001, 16'h8001, 16'd12345};
    drain_results();

    set_config(8'h0F, 8'h07);
    count_backlog = '{16'hFFFF, 16'h00FF, 16'hFF00};
    drain_results();

    set_config(8'h57, 8'hAB);
    count_backlog = '{16'h1234, 16'hFFFE};
    drain_results();

    for (p = 0; p < 10; p++) begin
      case (p)
        0: set_config(8'h00, 8'h07);
        1: set_config(8'h0F, 8'h00);
        2: set_config(8'hFF, 8'hFF);
        3: set_config(8'hF0, 8'h08);
        default: set_config(CFG_DATA_W'($urandom_range(255)), CFG_DATA_W'($urandom_range(255)));
      endcase
      n = (p == 0) ? 120 : 58;
      repeat (n) begin
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(3))
            0: v = '0;
            1: v = '1;
            2: v = 16'h0001;
            default: v = 16'h8000;
          endcase
        end else begin
          v = COUNT_W'($urandom_range(16'hFFFF));
        end
        count_backlog.push_back(v);
      end
      drain_results();
    end

    repeat (16) @(negedge clk);
    if (ah_expected.size() != 0)
      $error("%0d expected results never arrived", ah_expected.size());
    if (mismatches == 0 && ah_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
